// File: rtl/core/bfpd_pkg.sv
package bfpd_pkg;

   // default sizes, handed to the top level parameters
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_FACTOR_DEF  = 16;

   // fixed field widths
   localparam int PIX_W      = 32;
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 16;
   localparam int SHIFT_W    = 5;
   localparam int FACTOR_W   = 5;
   localparam int COLUMNS_W  = 11;
   localparam int SHIFTS_W   = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int LANES      = 3;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COLUMNS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_SHIFTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MAX        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MAX       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUE_COLOUR    = 3'd6;

   typedef struct packed {
      logic [FACTOR_W-1:0]  scale_factor;
      logic [COLUMNS_W-1:0] out_columns;
      logic [SHIFTS_W-1:0]  channel_shifts;
      logic [CHAN_W-1:0]    red_max;
      logic [CHAN_W-1:0]    green_max;
      logic [CHAN_W-1:0]    blue_max;
      logic                 true_colour;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scale_factor:   5'd1,
      out_columns:    11'd1,
      channel_shifts: 15'd16640,
      red_max:        8'd255,
      green_max:      8'd255,
      blue_max:       8'd255,
      true_colour:    1'b1
   };

   // one classified item on its way from front to back
   typedef struct packed {
      logic              first;
      logic              last;
      logic              row_end;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [PIX_W-1:0]  pixel;
   } job_type;

endpackage

// File: rtl/core/bfpd_req_if.sv
interface bfpd_req_if;
   logic                        valid;
   logic                        ready;
   logic [bfpd_pkg::PIX_W-1:0]  src_pixel;
   logic                        window_start;

   modport source (output valid, output src_pixel, output window_start, input ready);
   modport sink (input valid, input src_pixel, input window_start, output ready);
endinterface

// File: rtl/core/bfpd_rsp_if.sv
interface bfpd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfpd_pkg::PIX_W-1:0]  dst_pixel;
   logic                        row_end;

   modport source (output valid, output dst_pixel, output row_end, input ready);
   modport sink (input valid, input dst_pixel, input row_end, output ready);
endinterface

// File: rtl/core/bfpd_csr_if.sv
interface bfpd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bfpd_pkg::CSR_IDX_W-1:0]   index;
   logic [bfpd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/box_filter_pixel_downscaler.sv
// Box-filter downscaler for a raster pixel stream. Source pixels of a window
// come in on req_chan, window_start marking the first; each source row is
// out_columns * scale_factor pixels. In true-colour mode each channel is
// pulled out by shift and mask, summed over the factor-by-factor block in a
// per-column memory, divided by factor squared (truncating) and repacked; the
// result leaves on rsp_chan when the block's bottom-right pixel arrives. In
// indexed mode the block's top-left pixel is passed on as it arrives. Flow:
// the front takes one item a cycle, while the queue has room and no re-split
// runs, into a two-entry queue. The back works one item at a time through a
// read-modify-write of the sums memory: an item with no result passes idle
// and accumulate, a copied top-left pixel also output, a true-colour block
// end also the bit-serial divider, pack and output. A write to scale_factor
// holds off input while the column position is re-split for the new factor.
// Register writes belong in idle time; writes to indexes past the list are
// dropped. The sums memory has no reset and is only read where written.
module box_filter_pixel_downscaler #(
   parameter int MAX_COLUMNS = bfpd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_FACTOR  = bfpd_pkg::MAX_FACTOR_DEF
) (
   input  logic         clock,
   input  logic         reset,
   bfpd_req_if.sink     req_chan,
   bfpd_rsp_if.source   rsp_chan,
   bfpd_csr_if.sink     csr_chan
);

   localparam int FAC_W = $clog2(MAX_FACTOR + 1);
   localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int QW    = $clog2(MAX_COLUMNS) + $bits(bfpd_pkg::job_type);

   bfpd_pkg::cfg_type cfg_ff, cfg_in;
   logic [FAC_W-1:0]  f_eff;
   logic [CNT_W-1:0]  cols_eff;
   logic              factor_wr;

   logic              push_valid, push_ready;
   logic [QW-1:0]     push_data;
   logic              pop_valid, pop_ready;
   logic [QW-1:0]     pop_data;

   // register port never stalls
   assign csr_chan.ready = 1'b1;
   assign factor_wr = csr_chan.valid && (csr_chan.index == bfpd_pkg::CSR_SCALE_FACTOR);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            bfpd_pkg::CSR_SCALE_FACTOR: begin
               cfg_in.scale_factor = csr_chan.data[bfpd_pkg::FACTOR_W-1:0];
            end
            bfpd_pkg::CSR_OUT_COLUMNS: begin
               cfg_in.out_columns = csr_chan.data[bfpd_pkg::COLUMNS_W-1:0];
            end
            bfpd_pkg::CSR_CHANNEL_SHIFTS: begin
               cfg_in.channel_shifts = csr_chan.data[bfpd_pkg::SHIFTS_W-1:0];
            end
            bfpd_pkg::CSR_RED_MAX: begin
               cfg_in.red_max = csr_chan.data[bfpd_pkg::CHAN_W-1:0];
            end
            bfpd_pkg::CSR_GREEN_MAX: begin
               cfg_in.green_max = csr_chan.data[bfpd_pkg::CHAN_W-1:0];
            end
            bfpd_pkg::CSR_BLUE_MAX: begin
               cfg_in.blue_max = csr_chan.data[bfpd_pkg::CHAN_W-1:0];
            end
            bfpd_pkg::CSR_TRUE_COLOUR: begin
               cfg_in.true_colour = csr_chan.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bfpd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // zero means one, and both limits saturate at the build sizes
   always_comb begin
      if (cfg_ff.scale_factor == '0) begin
         f_eff = FAC_W'(1);
      end else if (32'(cfg_ff.scale_factor) > 32'(MAX_FACTOR)) begin
         f_eff = FAC_W'(MAX_FACTOR);
      end else begin
         f_eff = FAC_W'(cfg_ff.scale_factor);
      end
      if (cfg_ff.out_columns == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(cfg_ff.out_columns) > 32'(MAX_COLUMNS)) begin
         cols_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CNT_W'(cfg_ff.out_columns);
      end
   end

   // front: position tracking, channel pull-out, block classification
   bfpd_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_FACTOR  (MAX_FACTOR)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .f_eff      (f_eff),
      .cols_eff   (cols_eff),
      .factor_wr  (factor_wr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bfpd_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: accumulate, divide, repack, output register
   bfpd_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_FACTOR  (MAX_FACTOR)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .f_eff     (f_eff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/core/bfpd_queue.sv
module bfpd_queue #(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = bfpd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/bfpd_front.sv
module bfpd_front #(
   parameter int MAX_COLUMNS = bfpd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_FACTOR  = bfpd_pkg::MAX_FACTOR_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bfpd_req_if.sink                               req_chan,
   input  bfpd_pkg::cfg_type                      cfg,
   input  logic [$clog2(MAX_FACTOR+1)-1:0]        f_eff,
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]       cols_eff,
   input  logic                                   factor_wr,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output logic [$clog2(MAX_COLUMNS)+$bits(bfpd_pkg::job_type)-1:0] push_data
);

   localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int SUB_W  = $clog2(MAX_FACTOR);
   localparam int SC_W   = $clog2(MAX_COLUMNS * MAX_FACTOR);
   localparam int WID_W  = $clog2(MAX_COLUMNS * MAX_FACTOR + 1);
   localparam int RSC_W  = $clog2(SC_W + 1);

   // position: source column, and the same split into block column and sub column
   logic [SC_W-1:0]  sc_ff, sc_in;
   logic [COL_W-1:0] dcol_ff, dcol_in;
   logic [SUB_W-1:0] sub_ff, sub_in;
   logic [SUB_W-1:0] band_ff, band_in;

   // rebuild of block column / sub column after a factor change
   logic             rs_busy_ff, rs_busy_in;
   logic [RSC_W-1:0] rs_cnt_ff, rs_cnt_in;
   logic [FAC_W-1:0] rs_rem_ff, rs_rem_in;
   logic [SC_W-1:0]  rs_quot_ff, rs_quot_in;
   logic [FAC_W:0]   rs_trial;
   logic             rs_ge;
   logic [FAC_W-1:0] rs_rem_nx;
   logic [SC_W-1:0]  rs_quot_nx;

   logic [WID_W-1:0] row_width;
   logic [FAC_W-1:0] f_m1;
   logic [SC_W-1:0]  sc0, sc1;
   logic [COL_W-1:0] dcol0, dcol1;
   logic [SUB_W-1:0] sub0, sub1, band0, band1;
   logic             stale;
   logic [WID_W-1:0] sc_inc;
   logic [FAC_W-1:0] sub_nx, band_nx;
   logic             accept;
   bfpd_pkg::job_type job;

   assign row_width = WID_W'(cols_eff) * WID_W'(f_eff);
   assign f_m1      = f_eff - FAC_W'(1);

   assign req_chan.ready = push_ready && !rs_busy_ff;
   assign push_valid     = req_chan.valid && !rs_busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      // window start clears position, then stale values fold to zero
      sc0   = req_chan.window_start ? '0 : sc_ff;
      dcol0 = req_chan.window_start ? '0 : dcol_ff;
      sub0  = req_chan.window_start ? '0 : sub_ff;
      band0 = req_chan.window_start ? '0 : band_ff;
      stale = (WID_W'(sc0) >= row_width);
      sc1   = stale ? '0 : sc0;
      dcol1 = stale ? '0 : dcol0;
      sub1  = stale ? '0 : sub0;
      band1 = (FAC_W'(band0) >= f_eff) ? '0 : band0;

      job.first   = (band1 == '0) && (sub1 == '0);
      job.last    = (FAC_W'(band1) == f_m1) && (FAC_W'(sub1) == f_m1);
      job.row_end = (CNT_W'(dcol1) == cols_eff - CNT_W'(1));
      job.red     = bfpd_pkg::CHAN_W'(req_chan.src_pixel >> cfg.channel_shifts[14:10])
                    & cfg.red_max;
      job.green   = bfpd_pkg::CHAN_W'(req_chan.src_pixel >> cfg.channel_shifts[9:5])
                    & cfg.green_max;
      job.blue    = bfpd_pkg::CHAN_W'(req_chan.src_pixel >> cfg.channel_shifts[4:0])
                    & cfg.blue_max;
      job.pixel   = req_chan.src_pixel;

      sc_inc  = WID_W'(sc1) + WID_W'(1);
      sub_nx  = FAC_W'(sub1) + FAC_W'(1);
      band_nx = FAC_W'(band1) + FAC_W'(1);
   end

   assign push_data = {dcol1, job};

   // one quotient bit per cycle
   always_comb begin
      rs_trial   = {rs_rem_ff, rs_quot_ff[SC_W-1]};
      rs_ge      = (rs_trial >= {1'b0, f_eff});
      rs_rem_nx  = rs_ge ? FAC_W'(rs_trial - {1'b0, f_eff}) : FAC_W'(rs_trial);
      rs_quot_nx = {rs_quot_ff[SC_W-2:0], rs_ge};
   end

   always_comb begin
      sc_in      = sc_ff;
      dcol_in    = dcol_ff;
      sub_in     = sub_ff;
      band_in    = band_ff;
      rs_busy_in = rs_busy_ff;
      rs_cnt_in  = rs_cnt_ff;
      rs_rem_in  = rs_rem_ff;
      rs_quot_in = rs_quot_ff;
      if (factor_wr) begin
         rs_busy_in = 1'b1;
         rs_cnt_in  = RSC_W'(SC_W);
         rs_rem_in  = '0;
         rs_quot_in = sc_ff;
      end else if (rs_busy_ff) begin
         rs_rem_in  = rs_rem_nx;
         rs_quot_in = rs_quot_nx;
         rs_cnt_in  = rs_cnt_ff - RSC_W'(1);
         if (rs_cnt_ff == RSC_W'(1)) begin
            rs_busy_in = 1'b0;
            dcol_in    = rs_quot_nx[COL_W-1:0];
            sub_in     = rs_rem_nx[SUB_W-1:0];
         end
      end else if (accept) begin
         if (sc_inc >= row_width) begin
            sc_in   = '0;
            dcol_in = '0;
            sub_in  = '0;
            band_in = (band_nx >= f_eff) ? '0 : SUB_W'(band_nx);
         end else begin
            sc_in   = SC_W'(sc_inc);
            band_in = band1;
            if (sub_nx == f_eff) begin
               sub_in  = '0;
               dcol_in = dcol1 + COL_W'(1);
            end else begin
               sub_in  = SUB_W'(sub_nx);
               dcol_in = dcol1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff      <= '0;
         dcol_ff    <= '0;
         sub_ff     <= '0;
         band_ff    <= '0;
         rs_busy_ff <= 1'b0;
         rs_cnt_ff  <= '0;
      end else begin
         sc_ff      <= sc_in;
         dcol_ff    <= dcol_in;
         sub_ff     <= sub_in;
         band_ff    <= band_in;
         rs_busy_ff <= rs_busy_in;
         rs_cnt_ff  <= rs_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_rem_ff  <= rs_rem_in;
      rs_quot_ff <= rs_quot_in;
   end

endmodule

// File: rtl/core/bfpd_back.sv
module bfpd_back #(
   parameter int MAX_COLUMNS = bfpd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_FACTOR  = bfpd_pkg::MAX_FACTOR_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bfpd_pkg::cfg_type                      cfg,
   input  logic [$clog2(MAX_FACTOR+1)-1:0]        f_eff,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  logic [$clog2(MAX_COLUMNS)+$bits(bfpd_pkg::job_type)-1:0] pop_data,
   bfpd_rsp_if.source                             rsp_chan
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int JOB_W  = $bits(bfpd_pkg::job_type);
   localparam int AREA_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int SUM_W  = bfpd_pkg::SUM_W;
   localparam int PIX_W  = bfpd_pkg::PIX_W;
   localparam int LANES  = bfpd_pkg::LANES;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ACC  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_PACK = 5'b01000,
      ST_OUT  = 5'b10000
   } back_state_type;

   back_state_type    state_ff, state_in;
   bfpd_pkg::job_type job_ff, job_in;
   logic [COL_W-1:0]  dcol_ff, dcol_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  quot_ff [LANES];
   logic [SUM_W-1:0]  quot_in [LANES];
   logic [AREA_W-1:0] rem_ff [LANES];
   logic [AREA_W-1:0] rem_in [LANES];
   logic [PIX_W-1:0]  res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_pixel_ff, out_pixel_in;
   logic              out_row_end_ff, out_row_end_in;

   // per-column sums, lane 0 red in the low bits
   logic [LANES*SUM_W-1:0] sums_mem [MAX_COLUMNS];
   logic [LANES*SUM_W-1:0] rd_ff;
   logic [LANES*SUM_W-1:0] mem_wdata;
   logic                   mem_we, mem_re;

   logic [COL_W-1:0]                  pop_dcol;
   bfpd_pkg::job_type                 pop_job;
   logic [AREA_W-1:0]                 area;
   logic [bfpd_pkg::CHAN_W-1:0]       chan [LANES];
   logic [bfpd_pkg::SHIFT_W-1:0]      shift [LANES];
   logic [SUM_W-1:0]                  acc [LANES];
   logic [AREA_W:0]                   trial [LANES];
   logic [PIX_W-1:0]                  packed_pix;

   assign pop_dcol = pop_data[COL_W+JOB_W-1:JOB_W];
   assign pop_job  = bfpd_pkg::job_type'(pop_data[JOB_W-1:0]);
   assign area     = AREA_W'(f_eff) * AREA_W'(f_eff);

   assign chan[0]  = job_ff.red;
   assign chan[1]  = job_ff.green;
   assign chan[2]  = job_ff.blue;
   assign shift[0] = cfg.channel_shifts[14:10];
   assign shift[1] = cfg.channel_shifts[9:5];
   assign shift[2] = cfg.channel_shifts[4:0];

   always_comb begin
      packed_pix = '0;
      for (int i = 0; i < LANES; i++) begin
         acc[i] = job_ff.first ? SUM_W'(chan[i])
                               : rd_ff[i*SUM_W +: SUM_W] + SUM_W'(chan[i]);
         mem_wdata[i*SUM_W +: SUM_W] = acc[i];
         trial[i] = {rem_ff[i], quot_ff[i][SUM_W-1]};
         packed_pix = packed_pix + (PIX_W'(quot_ff[i]) << shift[i]);
      end
   end

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      dcol_in        = dcol_ff;
      cnt_in         = cnt_ff;
      res_in         = res_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      pop_ready      = 1'b0;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_pixel_in   = out_pixel_ff;
      out_row_end_in = out_row_end_ff;
      for (int i = 0; i < LANES; i++) begin
         quot_in[i] = quot_ff[i];
         rem_in[i]  = rem_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               job_in   = pop_job;
               dcol_in  = pop_dcol;
               mem_re   = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            mem_we = 1'b1;
            cnt_in = DCNT_W'(SUM_W);
            for (int i = 0; i < LANES; i++) begin
               quot_in[i] = acc[i];
               rem_in[i]  = '0;
            end
            if (cfg.true_colour && job_ff.last) begin
               state_in = ST_DIV;
            end else if (!cfg.true_colour && job_ff.first) begin
               res_in   = job_ff.pixel;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // restoring divide by the block area, three lanes side by side
            for (int i = 0; i < LANES; i++) begin
               if (trial[i] >= {1'b0, area}) begin
                  rem_in[i]  = AREA_W'(trial[i] - {1'b0, area});
                  quot_in[i] = {quot_ff[i][SUM_W-2:0], 1'b1};
               end else begin
                  rem_in[i]  = AREA_W'(trial[i]);
                  quot_in[i] = {quot_ff[i][SUM_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            res_in   = packed_pix;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in   = 1'b1;
               out_pixel_in   = res_ff;
               out_row_end_in = job_ff.row_end;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.dst_pixel = out_pixel_ff;
   assign rsp_chan.row_end   = out_row_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      dcol_ff        <= dcol_in;
      cnt_ff         <= cnt_in;
      res_ff         <= res_in;
      out_pixel_ff   <= out_pixel_in;
      out_row_end_ff <= out_row_end_in;
      for (int i = 0; i < LANES; i++) begin
         quot_ff[i] <= quot_in[i];
         rem_ff[i]  <= rem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[dcol_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= sums_mem[pop_dcol];
      end
   end

endmodule
